/* design/booth_signed_multiplier_unit_assert.svh */
// Assertion macros for the Booth multiplier unit.
// Expects i_clk and an active-low i_rst_n in the including module.
`ifndef BOOTH_SIGNED_MULTIPLIER_UNIT_ASSERT_SVH
`define BOOTH_SIGNED_MULTIPLIER_UNIT_ASSERT_SVH

// same-cycle implication
`define BSM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("booth multiplier check failed");

// next-cycle implication
`define BSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("booth multiplier check failed");

`endif

/* design/bsm_pkg.sv */
// Shared constants and types for the radix-2 Booth multiplier pipeline.
// No dependencies.
package bsm_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PRODUCT_WIDTH = 2 * OPERAND_WIDTH;
    localparam int NUM_STAGES    = OPERAND_WIDTH;

    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

    typedef struct packed {
        logic signed [OPERAND_WIDTH:0]   ac;
        logic        [OPERAND_WIDTH-1:0] mq;
        logic                            prev;
        logic signed [OPERAND_WIDTH-1:0] md;
    } t_booth;

endpackage

/* design/booth_signed_multiplier_unit.sv */
// Signed 16x16 radix-2 Booth multiplier, one decision step per pipeline stage.
// Depends on bsm_pkg, bsm_stage and booth_signed_multiplier_unit_assert.svh.
//
// Usage:
//   Input channel: i_valid, i_multiplicand, i_multiplier; the unit drives
//   o_stall. A request is taken at a rising edge with i_valid high and
//   o_stall low.
//   Output channel: o_valid, o_product; the receiver drives i_stall. A result
//   leaves at a rising edge with o_valid high and i_stall low.
//   Each request passes through one registered stage per Booth step, each
//   step with one 18-bit add/subtract.
//   Throughput: one request per cycle while i_stall is low, set by the 16-stage step pipeline.
//   Reset (synchronous, active low) drops every request in flight; o_valid
//   falls and o_stall is low afterwards.
//   A stalled receiver holds the last stage; earlier stages keep advancing
//   into empty slots, so requests are still taken until all 16 stages are
//   full. Nothing is lost or repeated across a stall.
//   o_product is the full 32-bit signed product; the most negative operand
//   pair gives +2^30 exactly.
module booth_signed_multiplier_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [bsm_pkg::OPERAND_WIDTH-1:0] i_multiplicand,
    input  logic signed [bsm_pkg::OPERAND_WIDTH-1:0] i_multiplier,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bsm_pkg::PRODUCT_WIDTH-1:0] o_product
);
    import bsm_pkg::*;
    `include "booth_signed_multiplier_unit_assert.svh"

    t_booth                stage_in;
    t_booth                data  [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld;
    logic [NUM_STAGES-1:0] adv;

    always_comb begin
        stage_in.ac   = '0;
        stage_in.mq   = i_multiplier;
        stage_in.prev = 1'b0;
        stage_in.md   = i_multiplicand;
    end

    // advance a stage when it is empty or the one after it advances
    always_comb begin
        adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld[k] || adv[k+1];
        end
    end

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_step
        if (g == 0) begin : g_first
            bsm_stage u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_valid   (i_valid),
                .i_data    (stage_in),
                .i_advance (adv[g]),
                .o_valid   (vld[g]),
                .o_data    (data[g])
            );
        end else begin : g_rest
            bsm_stage u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_valid   (vld[g-1]),
                .i_data    (data[g-1]),
                .i_advance (adv[g]),
                .o_valid   (vld[g]),
                .o_data    (data[g])
            );
        end
    end

    assign o_stall   = !adv[0];
    assign o_valid   = vld[NUM_STAGES-1];
    assign o_product = {data[NUM_STAGES-1].ac[OPERAND_WIDTH-1:0], data[NUM_STAGES-1].mq};

    `BSM_ASSERT_IMPL(a_full_stall, (&vld) && i_stall, o_stall)
    `BSM_ASSERT_IMPL(a_empty_head_ready, !vld[0], !o_stall)
    `BSM_ASSERT_NEXT(a_accept_lands, i_valid && !o_stall, vld[0])

endmodule

/* design/bsm_stage.sv */
// One registered Booth decision step: add/subtract/skip, then arithmetic shift.
// Depends on bsm_pkg.
module bsm_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bsm_pkg::t_booth i_data,
    input  logic           i_advance,
    output logic           o_valid,
    output bsm_pkg::t_booth o_data
);
    import bsm_pkg::*;

    logic                            r_valid;
    t_booth                          r_data;
    t_booth                          n_data;
    logic signed [OPERAND_WIDTH+1:0] ac_ext;
    logic signed [OPERAND_WIDTH+1:0] md_ext;
    logic signed [OPERAND_WIDTH+1:0] sum;

    always_comb begin
        ac_ext = {i_data.ac[OPERAND_WIDTH], i_data.ac};
        md_ext = {{2{i_data.md[OPERAND_WIDTH-1]}}, i_data.md};
        case ({i_data.mq[0], i_data.prev})
            BOOTH_ADD: sum = ac_ext + md_ext;
            BOOTH_SUB: sum = ac_ext - md_ext;
            default:   sum = ac_ext;
        endcase
        n_data.ac   = sum[OPERAND_WIDTH+1:1];
        n_data.mq   = {sum[0], i_data.mq[OPERAND_WIDTH-1:1]};
        n_data.prev = i_data.mq[0];
        n_data.md   = i_data.md;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* tb/testbench.sv */
// Self-checking bench for booth_signed_multiplier_unit: directed table, then random operand pairs.
// Random idling and one long receiver hold-off; results are checked against the table or a Booth-step predictor.
// Depends on bsm_pkg and the multiplier RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsm_pkg::*;

    localparam int RANDOM_REQUESTS = 1400;
    localparam int HOLD_AFTER      = 600;
    localparam int HOLD_CYCLES     = 200;

    typedef logic signed [OPERAND_WIDTH-1:0] t_operand;
    typedef logic signed [PRODUCT_WIDTH-1:0] t_product;

    typedef struct {
        t_operand multiplicand;
        t_operand multiplier;
        bit       known;
        t_product product;
    } t_directed_row;

    localparam int NUM_ROWS = 22;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_operand i_multiplicand = '0;
    t_operand i_multiplier = '0;
    logic     o_valid;
    logic     i_stall;
    t_product o_product;

    logic     rx_stall = 1'b0;
    logic     long_hold = 1'b0;
    int       request_count = 0;
    int       mismatch_count = 0;
    t_product pending_products[$];

    t_directed_row directed_rows [0:NUM_ROWS-1] = '{
        '{16'sh0000, 16'sh0000, 1'b1, 32'sh0000_0000},
        '{16'sh8000, 16'sh8000, 1'b1, 32'sh4000_0000},
        '{16'sh8000, 16'sh7fff, 1'b1, 32'shc000_8000},
        '{16'sh7fff, 16'sh8000, 1'b1, 32'shc000_8000},
        '{16'sh7fff, 16'sh7fff, 1'b1, 32'sh3fff_0001},
        '{16'shffff, 16'shffff, 1'b1, 32'sh0000_0001},
        '{16'sh0001, 16'shffff, 1'b1, 32'shffff_ffff},
        '{16'shffff, 16'sh0001, 1'b1, 32'shffff_ffff},
        '{16'sh8000, 16'sh0000, 1'b1, 32'sh0000_0000},
        '{16'sh0000, 16'sh8000, 1'b1, 32'sh0000_0000},
        '{16'sh8000, 16'sh0001, 1'b1, 32'shffff_8000},
        '{16'sh0001, 16'sh8000, 1'b1, 32'shffff_8000},
        '{16'sh8000, 16'shffff, 1'b1, 32'sh0000_8000},
        '{16'shffff, 16'sh8000, 1'b1, 32'sh0000_8000},
        '{16'sh0007, 16'sh5555, 1'b0, 32'sh0},
        '{16'sh5555, 16'shaaaa, 1'b0, 32'sh0},
        '{16'shaaaa, 16'sh5555, 1'b0, 32'sh0},
        '{16'sh1234, 16'sh7fff, 1'b0, 32'sh0},
        '{16'shfffd, 16'shaaaa, 1'b0, 32'sh0},
        '{16'sh00ff, 16'shff00, 1'b0, 32'sh0},
        '{16'sh8001, 16'sh8001, 1'b0, 32'sh0},
        '{16'sh3039, 16'she57b, 1'b0, 32'sh0}
    };

    assign i_stall = rx_stall | long_hold;

    booth_signed_multiplier_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_product      (o_product)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_product booth_product(input t_operand md, input t_operand mr);
        logic signed [OPERAND_WIDTH:0] acc;
        logic signed [OPERAND_WIDTH:0] md_ext;
        logic [OPERAND_WIDTH-1:0]      q;
        logic                          q_prev;
        acc = '0;
        md_ext = md;
        q = mr;
        q_prev = 1'b0;
        for (int k = 0; k < OPERAND_WIDTH; k++) begin
            case ({q[0], q_prev})
                BOOTH_ADD: acc = acc + md_ext;
                BOOTH_SUB: acc = acc - md_ext;
                default: ;
            endcase
            q_prev = q[0];
            q = {acc[0], q[OPERAND_WIDTH-1:1]};
            acc = acc >>> 1;
        end
        return {acc[OPERAND_WIDTH-1:0], q};
    endfunction

    function automatic t_operand draw_operand();
        t_operand v;
        int       k;
        k = $urandom_range(0, OPERAND_WIDTH - 1);
        case ($urandom_range(0, 9))
            0: v = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
            1: v = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
            2: v = '0;
            3: v = $urandom_range(0, 1) ? t_operand'(1) : t_operand'(-1);
            4: v = t_operand'(1) << k;
            5: v = ~(t_operand'(1) << k);
            default: v = t_operand'($urandom);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    bit sender_rush = 1'b0;

    task automatic send_request(input t_operand md, input t_operand mr, input bit known,
                                input t_product product);
        int gap;
        if ($urandom_range(0, 63) == 0)
            sender_rush = !sender_rush;
        gap = (sender_rush || long_hold) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_multiplicand <= md;
        i_multiplier <= mr;
        do @(posedge i_clk); while (o_stall);
        pending_products.push_back(known ? product : booth_product(md, mr));
        request_count++;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r])
            send_request(directed_rows[r].multiplicand, directed_rows[r].multiplier,
                         directed_rows[r].known, directed_rows[r].product);
        repeat (RANDOM_REQUESTS)
            send_request(draw_operand(), draw_operand(), 1'b0, '0);
        i_valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (2 * NUM_STAGES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hold the output long enough for the pipeline to fill and stall the input.
    initial begin
        wait (request_count >= HOLD_AFTER);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin : receiver
        bit rx_rush;
        int wait_cycles;
        rx_rush = 1'b0;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 63) == 0)
                rx_rush = !rx_rush;
            wait_cycles = rx_rush ? 0 : $urandom_range(0, 15);
            if (wait_cycles > 0) begin
                rx_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            rx_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_products.size() == 0) begin
                report_mismatch($sformatf("unexpected product %0d", o_product));
            end else if (o_product !== pending_products[0]) begin
                report_mismatch($sformatf("product %0d, want %0d", o_product,
                                          pending_products[0]));
                void'(pending_products.pop_front());
            end else begin
                void'(pending_products.pop_front());
            end
        end
    end
endmodule

/* sim.f */
+incdir+design
design/bsm_pkg.sv
design/bsm_stage.sv
design/booth_signed_multiplier_unit.sv
tb/testbench.sv
